FILE: hw/rtl/swpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_pkg - shared types and constants for the sliding-window peak finder
// Item layouts, register defaults and the cell control bundle.
// ----------------------------------------------------------------------------
package swpf_pkg;

    localparam int SAMPLE_WIDTH        = 32;
    localparam int INDEX_WIDTH         = 16;
    localparam int WIN_HALF_WIDTH      = 6;
    localparam int MAX_HALF_WINDOW_DEF = 32;
    localparam int MAX_LENGTH_DEF      = 65536;

    localparam logic [WIN_HALF_WIDTH-1:0] WIN_HALF_RESET = WIN_HALF_WIDTH'(10);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t sample_value;
        logic    first_sample;
    } swpf_in_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] peak_index;
        sample_t                peak_value;
    } swpf_out_t;

    // Control common to every cell of the row
    typedef struct packed {
        logic shift;    // take neighbor's sample
        logic capture;  // register compare flag against the broadcast center
    } swpf_cell_ctl_t;

endpackage

FILE: hw/rtl/swpf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_cell - one stage of the sample row
// Holds one sample, passes it on to the next cell, flags a larger value.
// ----------------------------------------------------------------------------
module swpf_cell (
    input  logic                    aclk,
    input  swpf_pkg::swpf_cell_ctl_t ctl,
    input  logic                    win_en,
    input  swpf_pkg::sample_t       din,
    input  swpf_pkg::sample_t       center,
    output swpf_pkg::sample_t       dout,
    output logic                    gt
);
    import swpf_pkg::*;

    sample_t data_reg;
    sample_t data_next;
    logic    gt_reg;
    logic    gt_next;

    always_comb begin
        data_next = ctl.shift ? din : data_reg;
        gt_next   = ctl.capture ? (win_en && (data_reg > center)) : gt_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        gt_reg   <= gt_next;
    end

    assign dout = data_reg;
    assign gt   = gt_reg;

endmodule

FILE: hw/rtl/sliding_window_peak_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_peak_finder_top - streaming local maximum detector
// Reports the center of each 2W+1 sample window when nothing in it is larger.
// ----------------------------------------------------------------------------
// Takes one sample item per cycle while no backpressure stalls the pipe; a
// peak item for it, if any, is loaded into the output register behind m_data.
// The last 2*MAX_HALF_WINDOW+1 samples sit in a row of cells that shifts by
// one on every stored sample; after that every cell compares its sample with
// the window center in parallel and registers the flag, and then the flags
// are ORed to load the output register. The row sets the window depth, the
// single compare per cell sets the one-item-per-cycle rate. Backpressure on
// m_ready stalls the pipe only once a result waits in the output register and
// another peak is ready behind it. A set restarts at index 0 on first_sample;
// past MAX_LENGTH samples nothing is stored or reported until the next
// first_sample. window_half above MAX_HALF_WINDOW acts as MAX_HALF_WINDOW;
// write it only while no item is in flight.
// ----------------------------------------------------------------------------
module sliding_window_peak_finder_top #(
    parameter int MAX_HALF_WINDOW = swpf_pkg::MAX_HALF_WINDOW_DEF,
    parameter int MAX_LENGTH      = swpf_pkg::MAX_LENGTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration: window_half
    input  logic                                  cfg_wen,
    input  logic [swpf_pkg::WIN_HALF_WIDTH-1:0]   cfg_wdata,
    // sample items
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  swpf_pkg::swpf_in_t                    s_data,
    // peak items
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output swpf_pkg::swpf_out_t                   m_data
);
    import swpf_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;       // cells in the row
    localparam int DW    = $clog2(DEPTH);                 // cell select width
    localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);   // effective W width
    localparam int CW    = $clog2(MAX_LENGTH + 1);        // sample count width
    // arithmetic width for index math: wide enough for count, 2W and output
    localparam int AW0   = (CW > HW + 1) ? CW : HW + 1;
    localparam int AW    = (AW0 > INDEX_WIDTH) ? AW0 : INDEX_WIDTH;

    localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_LENGTH);

    // ---------------- configuration ----------------
    logic [WIN_HALF_WIDTH-1:0] win_half_reg;
    logic [WIN_HALF_WIDTH-1:0] win_half_next;
    logic [HW-1:0]             w_eff;

    always_comb begin
        win_half_next = cfg_wen ? cfg_wdata : win_half_reg;
        if (int'(win_half_reg) > MAX_HALF_WINDOW) begin
            w_eff = HW'(MAX_HALF_WINDOW);
        end else begin
            w_eff = HW'(win_half_reg);
        end
    end

    // ---------------- pipeline control ----------------
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   v1_reg, v1_next;      // row shifted, compare pending
    logic                   elig1_reg, elig1_next;
    logic [INDEX_WIDTH-1:0] idx1_reg, idx1_next;
    logic [HW-1:0]          w1_reg, w1_next;
    logic                   v2_reg, v2_next;      // flags registered
    logic                   elig2_reg, elig2_next;
    logic [INDEX_WIDTH-1:0] idx2_reg, idx2_next;
    sample_t                val2_reg, val2_next;
    logic                   m_valid_reg, m_valid_next;
    swpf_out_t              m_data_reg, m_data_next;

    logic           accept;
    logic           store;
    logic           take2;
    logic           adv2;
    logic           peak2;
    logic [CW-1:0]  cnt_base;
    logic [AW-1:0]  n_ext;
    logic [AW-1:0]  w_ext;
    logic [AW-1:0]  center_ext;

    // ---------------- cell row ----------------
    swpf_cell_ctl_t cell_ctl;
    sample_t        cell_q   [DEPTH];
    logic [DEPTH-1:0] cell_gt;
    logic [DEPTH-1:0] win_en;
    logic [HW:0]    w_span;      // 2W, last cell in the window
    logic [DW-1:0]  center_sel;
    sample_t        center_val;

    assign w_span     = {w1_reg, 1'b0};
    assign center_sel = DW'(w1_reg);
    assign center_val = cell_q[center_sel];

    assign cell_ctl.shift   = store;
    assign cell_ctl.capture = take2;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign win_en[k] = (k <= int'(w_span));
        if (k == 0) begin : g_head
            swpf_cell u_cell (
                .aclk   (aclk),
                .ctl    (cell_ctl),
                .win_en (win_en[k]),
                .din    (s_data.sample_value),
                .center (center_val),
                .dout   (cell_q[k]),
                .gt     (cell_gt[k])
            );
        end else begin : g_body
            swpf_cell u_cell (
                .aclk   (aclk),
                .ctl    (cell_ctl),
                .win_en (win_en[k]),
                .din    (cell_q[k-1]),
                .center (center_val),
                .dout   (cell_q[k]),
                .gt     (cell_gt[k])
            );
        end
    end

    // ---------------- handshake and stage advance ----------------
    always_comb begin
        peak2   = elig2_reg && !(|cell_gt);
        adv2    = v2_reg && (!peak2 || !m_valid_reg || m_ready);
        take2   = v1_reg && (!v2_reg || adv2);
        s_ready = !v1_reg || take2;
        accept  = s_valid && s_ready;
    end

    // ---------------- sample count and window test ----------------
    always_comb begin
        cnt_base   = s_data.first_sample ? '0 : cnt_reg;
        store      = accept && (cnt_base < CNT_LIMIT);
        n_ext      = AW'(cnt_base);
        w_ext      = AW'(w_eff);
        center_ext = n_ext - w_ext;

        cnt_next   = cnt_reg;
        if (accept) begin
            cnt_next = (cnt_base < CNT_LIMIT) ? cnt_base + CW'(1) : CNT_LIMIT;
        end

        v1_next    = accept ? 1'b1 : (take2 ? 1'b0 : v1_reg);
        elig1_next = elig1_reg;
        idx1_next  = idx1_reg;
        w1_next    = w1_reg;
        if (accept) begin
            // centre needs W samples on both sides within the set
            elig1_next = (cnt_base < CNT_LIMIT) && (n_ext >= (w_ext << 1));
            idx1_next  = center_ext[INDEX_WIDTH-1:0];
            w1_next    = w_eff;
        end

        v2_next    = take2 ? 1'b1 : (adv2 ? 1'b0 : v2_reg);
        elig2_next = take2 ? elig1_reg  : elig2_reg;
        idx2_next  = take2 ? idx1_reg   : idx2_reg;
        val2_next  = take2 ? center_val : val2_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (adv2 && peak2) begin
            m_valid_next          = 1'b1;
            m_data_next.peak_index = idx2_reg;
            m_data_next.peak_value = val2_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_half_reg <= WIN_HALF_RESET;
            cnt_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            win_half_reg <= win_half_next;
            cnt_reg      <= cnt_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        elig1_reg  <= elig1_next;
        idx1_reg   <= idx1_next;
        w1_reg     <= w1_next;
        elig2_reg  <= elig2_next;
        idx2_reg   <= idx2_next;
        val2_reg   <= val2_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/swpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_checker - port-level checks for the peak finder
// Watches the top level's ports; bound to every instance of it.
// ----------------------------------------------------------------------------
module swpf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input swpf_pkg::swpf_out_t m_data
);
    import swpf_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("peak item changed or dropped while stalled");

    // input backs up only behind a stalled, full output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("peak item present after reset");

    // no peak item is present right out of reset, before any item could go in
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("peak item without any input item");

endmodule

bind sliding_window_peak_finder_top swpf_checker u_swpf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: dv/tb_sliding_window_peak_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_peak_finder_top - self-checking bench for the peak finder
// A short directed table covers extremes, ties, plateaus, restarts, a zero and
// an oversized window and a window change inside a set. Random sample sets
// under several window sizes follow, with idle bursts on both channels. A
// back-to-back set with a zero window and a restart closes the run with no
// idling. Every accepted sample feeds an in-bench peak tracker. Every peak
// item is checked in order against the queue of expected peaks.
// ----------------------------------------------------------------------------
module tb_sliding_window_peak_finder_top;
    import swpf_pkg::*;

    localparam int RING_DEPTH  = 2 * MAX_HALF_WINDOW_DEF + 1;
    localparam int RAND_ITEMS  = 1830;
    localparam int FINAL_ITEMS = 80;
    localparam int PIPE_GAP    = 8;        // quiet cycles that cover the pipe
    localparam int DRAIN_LIMIT = 4000;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PEAK} chk_e;
    typedef enum logic {ROW_SAMPLE, ROW_HALF} row_e;
    typedef enum logic [1:0] {VAL_FULL, VAL_NARROW, VAL_EXTREME, VAL_WALK} val_mode_e;

    typedef struct packed {
        row_e                      kind;
        logic [WIN_HALF_WIDTH-1:0] half;
        logic                      first;
        sample_t                   value;
        chk_e                      chk;
        swpf_out_t                 peak;
    } dir_row_t;

    localparam swpf_out_t NO_PEAK = '0;

    // directed rows; typed peaks only where obvious, no peak on CHK_NONE rows, the rest go to the tracker
    localparam dir_row_t DIR_TAB [21] = '{
        '{ROW_HALF,   6'd0,  1'b0, 32'sh0,         CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b1, 32'sh7FFF_FFFF, CHK_PEAK,  '{16'd0, 32'sh7FFF_FFFF}},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh8000_0000, CHK_PEAK,  '{16'd1, 32'sh8000_0000}},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh0,         CHK_PEAK,  '{16'd2, 32'sh0}},
        '{ROW_SAMPLE, 6'd0,  1'b1, 32'shFFFF_FFFF, CHK_PEAK,  '{16'd0, 32'shFFFF_FFFF}},
        '{ROW_HALF,   6'd1,  1'b0, 32'sh0,         CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b1, 32'sh8000_0000, CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh7FFF_FFFF, CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh8000_0000, CHK_PEAK,  '{16'd1, 32'sh7FFF_FFFF}},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh5,         CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh5,         CHK_PEAK,  '{16'd3, 32'sh5}},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh5,         CHK_PEAK,  '{16'd4, 32'sh5}},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh6,         CHK_NONE,  NO_PEAK},
        '{ROW_HALF,   6'd2,  1'b0, 32'sh0,         CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh0001_0000, CHK_MODEL, NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh8000_0001, CHK_MODEL, NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'shAAAA_AAAA, CHK_MODEL, NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh5555_5555, CHK_MODEL, NO_PEAK},
        '{ROW_HALF,   6'd63, 1'b0, 32'sh0,         CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b1, 32'sh0,         CHK_NONE,  NO_PEAK},
        '{ROW_SAMPLE, 6'd0,  1'b0, 32'sh1,         CHK_NONE,  NO_PEAK}
    };

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wen   = 1'b0;
    logic [WIN_HALF_WIDTH-1:0] cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    swpf_in_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    swpf_out_t                 m_data;

    // how the item on s_data is checked, travels with it
    chk_e      item_chk  = CHK_MODEL;
    swpf_out_t item_peak = '0;

    logic src_idle   = 1'b0;
    logic sink_idle  = 1'b0;
    int   stall_left = 0;

    // peak tracker state
    sample_t                   peak_ring [RING_DEPTH];
    logic [16:0]               set_count = '0;
    logic [WIN_HALF_WIDTH-1:0] half_reg  = WIN_HALF_RESET;
    swpf_out_t                 peak_q [$];

    int    err_count = 0;
    longint cycle_cnt = 0;

    sliding_window_peak_finder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stores one sample and returns 1 with the peak if its window center holds
    function automatic logic track_peak(input swpf_in_t it, output swpf_out_t res);
        int   n;
        int   w;
        int   ctr;
        int   j;
        logic hit;
        res = '0;
        if (it.first_sample) set_count = '0;
        if (set_count >= MAX_LENGTH_DEF) begin
            set_count = 17'(MAX_LENGTH_DEF);
            return 1'b0;
        end
        n = int'(set_count);
        peak_ring[n % RING_DEPTH] = it.sample_value;
        set_count = set_count + 17'd1;
        w = (half_reg > MAX_HALF_WINDOW_DEF) ? MAX_HALF_WINDOW_DEF : int'(half_reg);
        if (n < 2 * w) return 1'b0;
        ctr = n - w;
        hit = 1'b1;
        for (j = n - 2 * w; j <= n; j++) begin
            if (peak_ring[j % RING_DEPTH] > peak_ring[ctr % RING_DEPTH]) hit = 1'b0;
        end
        res.peak_index = ctr[INDEX_WIDTH-1:0];
        res.peak_value = peak_ring[ctr % RING_DEPTH];
        return hit;
    endfunction

    function automatic sample_t next_value(input val_mode_e mode, inout sample_t walk);
        case (mode)
            VAL_FULL:   return sample_t'($urandom);
            VAL_NARROW: return sample_t'(int'($urandom_range(0, 6)) - 3);
            VAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sh0;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            default: begin
                walk = walk + sample_t'(int'($urandom_range(0, 8)) - 4);
                return walk;
            end
        endcase
    endfunction

    task automatic note_error(input string what, input swpf_out_t want, input swpf_out_t got);
        err_count++;
        if (err_count <= 10)
            $display("%t %s: want idx %0d val %h, got idx %0d val %h", $time, what,
                     want.peak_index, want.peak_value, got.peak_index, got.peak_value);
    endtask

    // appends one expected peak at the tail of the queue
    function automatic void queue_peak(input swpf_out_t p);
        peak_q.insert(peak_q.size(), p);
    endfunction

    // peak checking first, then the tracker for the item accepted at this edge
    always @(posedge aclk) begin
        swpf_out_t want;
        swpf_out_t pred;
        logic      hit;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (peak_q.size() == 0) begin
                    note_error("unexpected peak", NO_PEAK, m_data);
                end else begin
                    want = peak_q.pop_front();
                    if (m_data.peak_index !== want.peak_index ||
                        m_data.peak_value !== want.peak_value)
                        note_error("peak mismatch", want, m_data);
                end
            end
            if (cfg_wen) half_reg = cfg_wdata;
            if (s_valid && s_ready) begin
                hit = track_peak(s_data, pred);
                case (item_chk)
                    CHK_MODEL: if (hit) queue_peak(pred);
                    CHK_PEAK:  queue_peak(item_peak);
                    default:   ;
                endcase
            end
        end
    end

    // receiver stalls in random bursts while sink_idle is set
    always @(posedge aclk) begin
        if (!sink_idle) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_sliding_window_peak_finder_top: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input logic first, input sample_t value, input chk_e chk,
                               input swpf_out_t peak);
        int gap;
        gap = (src_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_data.sample_value <= value;
        s_data.first_sample <= first;
        item_chk            <= chk;
        item_peak           <= peak;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid, wait for every expected peak plus a quiet pipe
    task automatic settle();
        int spin;
        int quiet;
        s_valid <= 1'b0;
        spin  = 0;
        quiet = 0;
        while (quiet < PIPE_GAP && spin < DRAIN_LIMIT) begin
            @(posedge aclk);
            spin++;
            quiet = (peak_q.size() == 0) ? quiet + 1 : 0;
        end
    endtask

    task automatic set_half(input logic [WIN_HALF_WIDTH-1:0] w);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        int        items;
        int        half;
        int        weff;
        int        sets;
        int        len;
        logic      first;
        val_mode_e mode;
        sample_t   walk;
        walk = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle = 1'b1;
        sink_idle <= 1'b1;

        for (int r = 0; r < $size(DIR_TAB); r++) begin
            if (DIR_TAB[r].kind == ROW_HALF)
                set_half(DIR_TAB[r].half);
            else
                send_sample(DIR_TAB[r].first, DIR_TAB[r].value, DIR_TAB[r].chk,
                            DIR_TAB[r].peak);
        end

        // random sets; a phase may carry on the previous set under a new width
        items = 0;
        while (items < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       half = 0;
                1:       half = 1;
                2:       half = MAX_HALF_WINDOW_DEF;
                3:       half = $urandom_range(MAX_HALF_WINDOW_DEF + 1, 63);
                4:       half = int'(WIN_HALF_RESET);
                default: half = $urandom_range(2, 8);
            endcase
            set_half(WIN_HALF_WIDTH'(half));
            weff = (half > MAX_HALF_WINDOW_DEF) ? MAX_HALF_WINDOW_DEF : half;
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle <= ($urandom_range(0, 3) != 0);
            sets = $urandom_range(1, 4);
            for (int s = 0; s < sets; s++) begin
                mode = val_mode_e'($urandom_range(0, 3));
                // some sets are kept to at most 2W+1 samples and may end before any center is reachable
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2 * weff + 1)
                                                  : 2 * weff + 1 + $urandom_range(0, 24);
                for (int k = 0; k < len; k++) begin
                    first = (k == 0) && !(s == 0 && $urandom_range(0, 3) == 0);
                    send_sample(first, next_value(mode, walk), CHK_MODEL, NO_PEAK);
                    items++;
                end
            end
        end

        // no idling from here: a back-to-back set with a peak per sample, then a restart
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        set_half('0);
        for (int k = 0; k < FINAL_ITEMS; k++)
            send_sample(k == 0, sample_t'($urandom), CHK_MODEL, NO_PEAK);
        for (int k = 0; k < 3; k++)
            send_sample(k == 0, next_value(VAL_EXTREME, walk), CHK_MODEL, NO_PEAK);

        settle();
        if (peak_q.size() != 0) begin
            err_count += peak_q.size();
            $display("%t %0d expected peaks never arrived", $time, peak_q.size());
        end
        if (err_count == 0)
            $display("tb_sliding_window_peak_finder_top: done, clean");
        else
            $display("tb_sliding_window_peak_finder_top: done, errors");
        $finish;
    end

endmodule

FILE: sliding_window_peak_finder_top.f
hw/rtl/swpf_pkg.sv
hw/rtl/swpf_cell.sv
hw/rtl/sliding_window_peak_finder_top.sv
hw/rtl/swpf_checker.sv
dv/tb_sliding_window_peak_finder_top.sv
